### rtl/assert_macros.svh
// Assertion macros for the checker file of the position solver.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, off while reset is high.
`define BLPS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also during reset.
`define BLPS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/blps_pkg.sv
// Package of the bearing lines position solver: constants, item types, states, helpers.
// No dependencies.
`timescale 1ns / 1ps

package blps_pkg;

  localparam int MAX_LINES = 64;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int LINE_W    = 48 + 48 + 32 + 32;

  localparam logic [31:0]  STEP_INIT  = 32'd10 << 28;
  localparam logic [63:0]  DECAY_Q30  = 64'd1020054733;
  localparam logic [15:0]  ITER_RESET = 16'd100;
  localparam logic [47:0]  TOL_RESET  = 48'd1 << FRAC_BITS;
  localparam logic [47:0]  RES_RESET  = 48'd100 << FRAC_BITS;
  localparam logic [7:0]   DIV_SHORT  = 8'd64;
  localparam logic [7:0]   DIV_LONG   = 8'd128;
  localparam logic [6:0]   SQRT_STEPS = 7'd64;
  localparam logic [4:0]   SH_DIR     = 5'd30;
  localparam logic [4:0]   SH_STEP    = 5'd28;

  localparam logic [1:0] CFG_ITER_LIMIT = 2'd0;
  localparam logic [1:0] CFG_GRAD_TOL   = 2'd1;
  localparam logic [1:0] CFG_RES_LIMIT  = 2'd2;

  typedef struct packed {
    logic signed [47:0] anchor_x;
    logic signed [47:0] anchor_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [47:0] guess_x;
    logic signed [47:0] guess_y;
    logic               last_line;
  } line_t;

  typedef struct packed {
    logic               converged;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [47:0]        rms_residual;
    logic [15:0]        iterations_used;
  } result_t;

  typedef enum logic [4:0] {
    S_LOAD, S_WAIT, S_TOL, S_ITER, S_RD, S_VEC, S_M1, S_M2, S_M3, S_M4, S_SQ,
    S_DIVX, S_DIVY, S_G2X, S_G2Y, S_UX, S_UY, S_DEC, S_RDIV, S_ROOT, S_FIN
  } state_t;

  function automatic logic [63:0] abs64(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] sext48(logic [47:0] a);
    return {{16{a[47]}}, a};
  endfunction

  // round half away from zero, shift right, saturate to signed 64
  function automatic logic [63:0] round_sat(logic [127:0] p, logic neg, logic [4:0] sh);
    logic [127:0] r;
    logic [127:0] q;
    r = p + (128'd1 << (sh - 5'd1));
    q = r >> sh;
    if (q[127:63] != '0) return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? (64'd0 - q[63:0]) : q[63:0];
  endfunction

  function automatic logic [63:0] sadd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic logic [47:0] sat48(logic [63:0] a);
    if (!a[63] && a[62:47] != '0) return 48'h7FFF_FFFF_FFFF;
    if (a[63] && a[62:47] != '1) return 48'h8000_0000_0000;
    return a[47:0];
  endfunction

endpackage

### rtl/blps_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module blps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bearing_lines_position_solver.sv
// Top level of the bearing lines position solver: line store, sequencer, arithmetic units.
// Depends on blps_pkg and blps_ram.
`timescale 1ns / 1ps
//
// Usage:
// - item channel (item_valid/item_ready/item): one bearing line per item, one per
//   cycle while loading. Lines past MAX_LINES are dropped. An item with last_line
//   set ends the set, takes guess_x/guess_y and starts the solve.
// - result channel (result_valid/result_ready/result): one item per solve.
// - cfg channel: register writes, always ready; write only between sets.
// - Solve: per descent iteration, four 4-partial multiplies per line on the
//   shared 32x32 multiplier, plus two 64-step divides and the update multiplies;
//   then one more pass over the lines, a 128-step divide and a 64-step square root.
// - Fewer than two lines: no solve; the sequencer goes straight to S_FIN and registers the result.
// - Reset clears the line count and result_valid, and sets the registers to their defaults.
// - A finished result stays in the output register while the receiver stalls;
//   new lines are taken meanwhile, and the next result waits until it drains.

module bearing_lines_position_solver
  import blps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  line_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state, state_next, ret, ret_next;

  logic [15:0]       iter_limit;
  logic [47:0]       grad_tol, res_limit;
  logic [CNT_W-1:0]  line_count, n;
  logic [ADDR_W-1:0] idx;
  logic              mode_rms, conv;
  logic [47:0]       ex, ey, rms;
  logic [31:0]       step;
  logic [15:0]       iter;
  logic [63:0]       vx, vy, dxr, dyr, t1, dot, px, gsx, gsy, gx, gy;
  logic [127:0]      tol2, mag, rsum;

  logic              accept, fits, last_of_pass;
  logic [CNT_W-1:0]  n_c;
  logic [LINE_W-1:0] rdata;
  logic [63:0]       vx_c, vy_c, t2_c, py_c, gq_c, post30, post28;
  logic [127:0]      mag2_c;

  // multiplier
  logic              mul_start, mbusy, mneg;
  logic [63:0]       mul_a, mul_b, ma, mb, pp;
  logic [2:0]        mph;
  logic [1:0]        ppk;
  logic [127:0]      acc;

  // divider
  logic              div_start, div_long, dneg;
  logic [127:0]      div_val, dvd;
  logic [CNT_W-1:0]  drem;
  logic [7:0]        dcnt;
  logic [CNT_W:0]    d_r2, d_sub;
  logic              d_ge;

  // square root
  logic              sq_start;
  logic [127:0]      sq_v;
  logic [66:0]       sq_rem, s_rem2, s_trial;
  logic [63:0]       sq_root;
  logic [6:0]        sq_cnt;
  logic              s_ge;

  assign item_ready = (state == S_LOAD);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign fits       = line_count < CNT_W'(MAX_LINES);
  assign n_c        = line_count + CNT_W'(fits);
  assign last_of_pass = ({1'b0, idx} + CNT_W'(1)) == n;

  blps_ram #(.WIDTH(LINE_W), .DEPTH(MAX_LINES)) u_store (
    .clk   (clk),
    .we    (accept && fits),
    .waddr (line_count[ADDR_W-1:0]),
    .wdata ({item.anchor_x, item.anchor_y, item.dir_x, item.dir_y}),
    .raddr (idx),
    .rdata (rdata)
  );

  assign vx_c   = sext48(ex) - sext48(rdata[159:112]);
  assign vy_c   = sext48(ey) - sext48(rdata[111:64]);
  assign post30 = round_sat(acc, mneg, SH_DIR);
  assign post28 = round_sat(acc, mneg, SH_STEP);
  assign t2_c   = post30;
  assign py_c   = vy - post30;
  assign gq_c   = dneg ? (64'd0 - dvd[63:0]) : dvd[63:0];
  assign mag2_c = mag + acc;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    ret_next   = ret;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_long   = 1'b0;
    div_val    = '0;
    sq_start   = 1'b0;
    case (state)
      S_LOAD: begin
        if (accept && item.last_line) begin
          if (n_c < CNT_W'(2)) begin
            state_next = S_FIN;
          end else begin
            mul_start  = 1'b1;
            mul_a      = {16'd0, grad_tol};
            mul_b      = {16'd0, grad_tol};
            ret_next   = S_TOL;
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (!mbusy && dcnt == '0 && sq_cnt == '0) state_next = ret;
      end
      S_TOL:  state_next = S_ITER;
      S_ITER: state_next = S_RD;
      S_RD:   state_next = S_VEC;
      S_VEC: begin
        mul_start  = 1'b1;
        mul_a      = vx_c;
        mul_b      = mode_rms ? {{32{rdata[31]}}, rdata[31:0]} : {{32{rdata[63]}}, rdata[63:32]};
        ret_next   = S_M1;
        state_next = S_WAIT;
      end
      S_M1: begin
        mul_start  = 1'b1;
        mul_a      = vy;
        mul_b      = mode_rms ? dxr : dyr;
        ret_next   = S_M2;
        state_next = S_WAIT;
      end
      S_M2: begin
        mul_start  = 1'b1;
        state_next = S_WAIT;
        if (mode_rms) begin
          mul_a    = t1 - t2_c;
          mul_b    = t1 - t2_c;
          ret_next = S_SQ;
        end else begin
          mul_a    = t1 + t2_c;
          mul_b    = dxr;
          ret_next = S_M3;
        end
      end
      S_M3: begin
        mul_start  = 1'b1;
        mul_a      = dot;
        mul_b      = dyr;
        ret_next   = S_M4;
        state_next = S_WAIT;
      end
      S_M4, S_SQ: begin
        if (last_of_pass) begin
          div_start  = 1'b1;
          state_next = S_WAIT;
          if (state == S_SQ) begin
            div_long = 1'b1;
            div_val  = rsum + acc;
            ret_next = S_RDIV;
          end else begin
            div_val  = {sadd64(gsx, sadd64(px, px)), 64'd0};
            ret_next = S_DIVX;
          end
        end else begin
          state_next = S_RD;
        end
      end
      S_DIVX: begin
        div_start  = 1'b1;
        div_val    = {gsy, 64'd0};
        ret_next   = S_DIVY;
        state_next = S_WAIT;
      end
      S_DIVY: begin
        mul_start  = 1'b1;
        mul_a      = gx;
        mul_b      = gx;
        ret_next   = S_G2X;
        state_next = S_WAIT;
      end
      S_G2X: begin
        mul_start  = 1'b1;
        mul_a      = gy;
        mul_b      = gy;
        ret_next   = S_G2Y;
        state_next = S_WAIT;
      end
      S_G2Y: begin
        if (mag2_c < tol2) begin
          state_next = S_RD;
        end else begin
          mul_start  = 1'b1;
          mul_a      = {32'd0, step};
          mul_b      = gx;
          ret_next   = S_UX;
          state_next = S_WAIT;
        end
      end
      S_UX: begin
        mul_start  = 1'b1;
        mul_a      = {32'd0, step};
        mul_b      = gy;
        ret_next   = S_UY;
        state_next = S_WAIT;
      end
      S_UY: begin
        mul_start  = 1'b1;
        mul_a      = {32'd0, step};
        mul_b      = DECAY_Q30;
        ret_next   = S_DEC;
        state_next = S_WAIT;
      end
      S_DEC:  state_next = S_ITER;
      S_RDIV: begin
        sq_start   = 1'b1;
        ret_next   = S_ROOT;
        state_next = S_WAIT;
      end
      S_ROOT: state_next = S_FIN;
      S_FIN: begin
        if (!result_valid || result_ready) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      ret   <= S_LOAD;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      result_valid <= 1'b0;
      iter_limit   <= ITER_RESET;
      grad_tol     <= TOL_RESET;
      res_limit    <= RES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ITER_LIMIT: iter_limit <= cfg_data[15:0];
          CFG_GRAD_TOL:   grad_tol   <= cfg_data[47:0];
          CFG_RES_LIMIT:  res_limit  <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready && state != S_FIN) result_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (item.last_line) begin
              line_count <= '0;
              n          <= n_c;
              ex         <= item.guess_x;
              ey         <= item.guess_y;
              step       <= STEP_INIT;
              iter       <= '0;
              conv       <= 1'b0;
              rms        <= '0;
            end else if (fits) begin
              line_count <= line_count + CNT_W'(1);
            end
          end
        end
        S_TOL: tol2 <= acc;
        S_ITER: begin
          idx      <= '0;
          gsx      <= '0;
          gsy      <= '0;
          rsum     <= '0;
          mode_rms <= !(iter < iter_limit);
        end
        S_VEC: begin
          vx  <= vx_c;
          vy  <= vy_c;
          dxr <= {{32{rdata[63]}}, rdata[63:32]};
          dyr <= {{32{rdata[31]}}, rdata[31:0]};
        end
        S_M1: t1 <= post30;
        S_M2: dot <= t1 + t2_c;
        S_M3: px <= vx - post30;
        S_M4: begin
          gsx <= sadd64(gsx, sadd64(px, px));
          gsy <= sadd64(gsy, sadd64(py_c, py_c));
          idx <= idx + ADDR_W'(1);
        end
        S_SQ: begin
          rsum <= rsum + acc;
          idx  <= idx + ADDR_W'(1);
        end
        S_DIVX: gx <= gq_c;
        S_DIVY: gy <= gq_c;
        S_G2X:  mag <= acc;
        S_G2Y: begin
          if (mag2_c < tol2) begin
            conv     <= 1'b1;
            mode_rms <= 1'b1;
            idx      <= '0;
            rsum     <= '0;
          end
        end
        S_UX: ex <= sat48(sadd64(sext48(ex), 64'd0 - post28));
        S_UY: ey <= sat48(sadd64(sext48(ey), 64'd0 - post28));
        S_DEC: begin
          step <= post30[31:0];
          iter <= iter + 16'd1;
        end
        S_ROOT: begin
          if (sq_root > {16'd0, res_limit}) conv <= 1'b0;
          rms <= (sq_root[63:48] != '0) ? '1 : sq_root[47:0];
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            result_valid           <= 1'b1;
            result.converged       <= conv;
            result.pos_x           <= ex;
            result.pos_y           <= ey;
            result.rms_residual    <= rms;
            result.iterations_used <= iter;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- shared multiplier, 4 partial products ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (mul_start) begin
      ma    <= abs64(mul_a);
      mb    <= abs64(mul_b);
      mneg  <= mul_a[63] ^ mul_b[63];
      mph   <= '0;
      acc   <= '0;
      mbusy <= 1'b1;
    end else if (mbusy) begin
      pp  <= (mph[0] ? ma[63:32] : ma[31:0]) * (mph[1] ? mb[63:32] : mb[31:0]);
      ppk <= 2'(mph[0]) + 2'(mph[1]);
      if (mph != 3'd0) acc <= acc + ({64'd0, pp} << {ppk, 5'd0});
      mph <= mph + 3'd1;
      if (mph == 3'd4) mbusy <= 1'b0;
    end
  end

  // ---------------- restoring divider by line count ----------------
  assign d_r2  = {drem, dvd[127]};
  assign d_ge  = d_r2 >= {1'b0, n};
  assign d_sub = d_r2 - {1'b0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (div_start) begin
      dneg <= !div_long && div_val[127];
      dvd  <= div_long ? div_val : {abs64(div_val[127:64]), 64'd0};
      drem <= '0;
      dcnt <= div_long ? DIV_LONG : DIV_SHORT;
    end else if (dcnt != '0) begin
      drem <= d_ge ? d_sub[CNT_W-1:0] : d_r2[CNT_W-1:0];
      dvd  <= {dvd[126:0], d_ge};
      dcnt <= dcnt - 8'd1;
    end
  end

  // ---------------- bitwise square root ----------------
  assign s_rem2  = {sq_rem[64:0], sq_v[127:126]};
  assign s_trial = {1'b0, sq_root, 2'b01};
  assign s_ge    = s_rem2 >= s_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (sq_start) begin
      sq_v    <= dvd;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= SQRT_STEPS;
    end else if (sq_cnt != '0) begin
      sq_rem  <= s_ge ? (s_rem2 - s_trial) : s_rem2;
      sq_root <= {sq_root[62:0], s_ge};
      sq_v    <= {sq_v[125:0], 2'b00};
      sq_cnt  <= sq_cnt - 7'd1;
    end
  end

endmodule

### rtl/blps_checker.sv
// Port-level checks for the bearing lines position solver, bound to the top level.
// Depends on blps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blps_checker
  import blps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input line_t   item,
  input logic    result_valid,
  input logic    result_ready
);

  `BLPS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result after reset")
  `BLPS_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid, "result dropped")
  `BLPS_ASSERT(a_solve_busy, clk, rst, item_valid && item_ready && item.last_line |=> !item_ready, "item taken during solve")

endmodule

bind bearing_lines_position_solver blps_checker u_blps_checker (.*);

### verif/tb_top.sv
// Self-checking bench for bearing_lines_position_solver: directed and random line sets with
// a bit-exact gradient-descent predictor. Depends on blps_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_top;
  import blps_pkg::*;

  localparam longint S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64MIN = 64'sh8000_0000_0000_0000;
  localparam longint S48MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48MIN = 64'shFFFF_8000_0000_0000;
  localparam logic [47:0] U48MAX = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  line_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ITER_LIMIT;
  logic [63:0] cfg_data = '0;

  bearing_lines_position_solver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_t pending_lines[$];
  result_t expected_fixes[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int fixes_checked = 0;
  int lines_sent = 0;

  // predictor state
  longint st_ox[MAX_LINES], st_oy[MAX_LINES], st_dx[MAX_LINES], st_dy[MAX_LINES];
  int stored_n = 0;
  logic [15:0] iter_limit = ITER_RESET;
  logic [47:0] grad_tol = TOL_RESET;
  logic [47:0] res_limit = RES_RESET;

  function automatic longint mul_round(longint a, longint b, int sh);
    logic neg;
    logic [63:0] ua, ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = a[63] ? 64'd0 - a : a;
    ub = b[63] ? 64'd0 - b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p[127:63] != '0) return neg ? S64MIN : S64MAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64MIN : S64MAX;
    return s;
  endfunction

  function automatic longint clamp48(longint a);
    return a > S48MAX ? S48MAX : (a < S48MIN ? S48MIN : a);
  endfunction

  function automatic longint sx48(logic [47:0] v);
    return longint'({{16{v[47]}}, v});
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'({{32{v[31]}}, v});
  endfunction

  function automatic logic [127:0] sq64(logic [63:0] a);
    return {64'd0, a} * {64'd0, a};
  endfunction

  task automatic solve_line(line_t it);
    int n;
    longint ex, ey, vx, vy, dot, px, py, sumx, sumy, gx, gy, d;
    logic [63:0] stp, root, cand;
    logic [127:0] tol2, mag2, acc, quo;
    logic [15:0] iters;
    logic conv;
    result_t r;
    if (stored_n < MAX_LINES) begin
      st_ox[stored_n] = sx48(it.anchor_x);
      st_oy[stored_n] = sx48(it.anchor_y);
      st_dx[stored_n] = sx32(it.dir_x);
      st_dy[stored_n] = sx32(it.dir_y);
      stored_n++;
    end
    if (!it.last_line) return;
    n = stored_n;
    stored_n = 0;
    ex = sx48(it.guess_x);
    ey = sx48(it.guess_y);
    stp = 64'(STEP_INIT);
    iters = 0;
    conv = 1'b0;
    root = 0;
    if (n >= 2) begin
      tol2 = sq64({16'd0, grad_tol});
      while (iters < iter_limit) begin
        sumx = 0;
        sumy = 0;
        for (int i = 0; i < n; i++) begin
          vx = ex - st_ox[i];
          vy = ey - st_oy[i];
          dot = mul_round(vx, st_dx[i], 30) + mul_round(vy, st_dy[i], 30);
          px = vx - mul_round(dot, st_dx[i], 30);
          py = vy - mul_round(dot, st_dy[i], 30);
          sumx = add_sat(sumx, add_sat(px, px));
          sumy = add_sat(sumy, add_sat(py, py));
        end
        gx = sumx / longint'(n);
        gy = sumy / longint'(n);
        mag2 = sq64(gx[63] ? 64'd0 - gx : gx) + sq64(gy[63] ? 64'd0 - gy : gy);
        if (mag2 < tol2) begin
          conv = 1'b1;
          break;
        end
        ex = clamp48(add_sat(ex, -mul_round(longint'(stp), gx, 28)));
        ey = clamp48(add_sat(ey, -mul_round(longint'(stp), gy, 28)));
        stp = (stp * DECAY_Q30 + (64'd1 << 29)) >> 30;
        iters++;
      end
      acc = 0;
      for (int i = 0; i < n; i++) begin
        vx = ex - st_ox[i];
        vy = ey - st_oy[i];
        d = mul_round(vx, st_dy[i], 30) - mul_round(vy, st_dx[i], 30);
        acc = acc + sq64(d[63] ? 64'd0 - d : d);
      end
      quo = acc / 128'(n);
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (sq64(cand) <= quo) root = cand;
      end
      if (root > {16'd0, res_limit}) conv = 1'b0;
      if (root > {16'd0, U48MAX}) root = {16'd0, U48MAX};
    end
    r.converged = conv;
    r.pos_x = ex[47:0];
    r.pos_y = ey[47:0];
    r.rms_residual = root[47:0];
    r.iterations_used = iters;
    expected_fixes.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        solve_line(item);
        lines_sent++;
      end
      if (!item_valid || item_ready) begin
        if (pending_lines.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_lines.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_fixes.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          result_t e;
          e = expected_fixes.pop_front();
          fixes_checked++;
          if (result.converged !== e.converged) begin
            $display("%0t: converged exp %0d got %0d", $time, e.converged, result.converged);
            error_count++;
          end
          if (result.pos_x !== e.pos_x) begin
            $display("%0t: pos_x exp %h got %h", $time, e.pos_x, result.pos_x);
            error_count++;
          end
          if (result.pos_y !== e.pos_y) begin
            $display("%0t: pos_y exp %h got %h", $time, e.pos_y, result.pos_y);
            error_count++;
          end
          if (result.rms_residual !== e.rms_residual) begin
            $display("%0t: rms exp %h got %h", $time, e.rms_residual, result.rms_residual);
            error_count++;
          end
          if (result.iterations_used !== e.iterations_used) begin
            $display("%0t: iterations exp %0d got %0d", $time, e.iterations_used,
                     result.iterations_used);
            error_count++;
          end
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic line_t mk_line(longint ox, longint oy, longint dx, longint dy,
                                    longint gx, longint gy, logic last);
    line_t l;
    l.anchor_x = ox[47:0];
    l.anchor_y = oy[47:0];
    l.dir_x = dx[31:0];
    l.dir_y = dy[31:0];
    l.guess_x = gx[47:0];
    l.guess_y = gy[47:0];
    l.last_line = last;
    return l;
  endfunction

  function automatic longint near_pos();
    return longint'($urandom_range(0, 32'h0200_0000)) - 64'sd33554432;
  endfunction

  function automatic longint raw48();
    return longint'({$urandom, $urandom});
  endfunction

  function automatic line_t wellformed_line(logic last);
    longint dx, dy;
    dx = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
    dy = longint'($rtoi($sqrt(2.0 ** 60 - real'(dx) * real'(dx))));
    if ($urandom_range(1)) dy = -dy;
    return mk_line(near_pos(), near_pos(), dx, dy, near_pos(), near_pos(), last);
  endfunction

  task automatic queue_set(int n, bit noisy);
    line_t l;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(9) == 0)
        l = mk_line(raw48(), raw48(), longint'($urandom), longint'($urandom),
                    raw48(), raw48(), 1'b0);
      else
        l = wellformed_line(1'b0);
      l.last_line = (i == n - 1);
      pending_lines.push_back(l);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ITER_LIMIT: iter_limit = val[15:0];
      CFG_GRAD_TOL:   grad_tol = val[47:0];
      CFG_RES_LIMIT:  res_limit = val[47:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    forever begin
      @(posedge clk);
      #1;
      if (pending_lines.size() == 0 && !item_valid && expected_fixes.size() == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  int phase_iters[8] = '{0, 3, 65535, 5, 2, 4, 1, 6};
  int n_sets = 0;

  initial begin
    longint tolv, resv;
    int sent_in_phase, nl;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    pending_lines.push_back(mk_line(near_pos(), near_pos(), 64'sd1073741824, 0,
                                    S48MAX, S48MAX, 1'b1));
    pending_lines.push_back(mk_line(S48MAX, S48MAX, 64'sd1073741824, 0, 0, 0, 1'b0));
    pending_lines.push_back(mk_line(S48MIN, S48MIN, 0, -64'sd1073741824,
                                    S48MIN, S48MIN, 1'b1));
    pending_lines.push_back(mk_line(0, 0, 64'sh7FFF_FFFF, 64'shFFFF_FFFF_8000_0000,
                                    0, 0, 1'b0));
    pending_lines.push_back(mk_line(65536, -65536, -64'sd1073741824, 64'sd1073741824,
                                    0, 0, 1'b1));
    queue_set(3, 0);
    queue_set(4, 0);
    queue_set(2, 0);
    n_sets = 6;
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      case (p)
        2: begin tolv = U48MAX; resv = U48MAX; end
        3: begin tolv = 0; resv = 0; end
        5: begin tolv = 0; resv = U48MAX; end
        default: begin
          tolv = longint'($urandom_range(0, 32'h0100_0000));
          resv = longint'({$urandom_range(0, 16'hFFFF), $urandom});
        end
      endcase
      write_reg(CFG_ITER_LIMIT, 64'(phase_iters[p]));
      write_reg(CFG_GRAD_TOL, tolv);
      write_reg(CFG_RES_LIMIT, resv);
      sent_in_phase = 0;
      if (p == 4) begin
        queue_set(70, 0);
        sent_in_phase += 70;
        n_sets++;
      end
      while (sent_in_phase < 240) begin
        nl = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : $urandom_range(2, 4);
        queue_set(nl, p != 2);
        sent_in_phase += nl;
        n_sets++;
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d lines in %0d sets over 8 register settings and 4 idle patterns,",
             lines_sent, n_sets);
    $display("%0d solver results compared, %0d mismatches.", fixes_checked, error_count);
    if (error_count == 0 && expected_fixes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
